### hw/rtl/mapped_area_insertion_sorter_assert.svh
// Assertion macros used by the sorter top level.
// Each expects clk and arst_n in scope.
`ifndef MAPPED_AREA_INSERTION_SORTER_ASSERT_SVH
`define MAPPED_AREA_INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication.
`define MAIS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MAIS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mais_pkg.sv
package mais_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef struct packed {
		logic [63:0] start_address;
		logic [63:0] area_length;
		logic [63:0] area_offset;
		logic [2:0]  permissions;
		logic [5:0]  area_id;
		logic        last_entry;
	} in_word_t;

	typedef struct packed {
		logic [63:0] sorted_start;
		logic [63:0] sorted_length;
		logic [63:0] sorted_offset;
		logic [2:0]  sorted_permissions;
		logic [5:0]  sorted_id;
		logic        last_result;
		logic        overflow;
	} out_word_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] len;
		logic [63:0] off;
		logic [2:0]  perm;
		logic [5:0]  id;
	} rec_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} cell_ctl_t;

endpackage

### hw/rtl/mais_cell.sv
module mais_cell import mais_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      first_free,
	input  logic      left_gt,
	input  rec_t      new_rec,
	input  rec_t      left_rec,
	input  rec_t      right_rec,
	output rec_t      rec,
	output logic      gt
);

	rec_t rec_q;

	assign gt  = occupied && (rec_q.key > new_rec.key);
	assign rec = rec_q;

	// Strictly greater keys move right, so equal keys keep arrival order.
	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			rec_q <= right_rec;
		end else if (ctl.insert && (gt || first_free)) begin
			rec_q <= left_gt ? left_rec : new_rec;
		end
	end

endmodule

### hw/rtl/mapped_area_insertion_sorter.sv
// Stable insertion sorter for memory-mapping records, MAX_ENTRIES cells deep.
// While a set fills, one record is taken per cycle: every cell compares its
// key with the incoming one and the row shifts right behind the insertion
// point in the same cycle. The word marked last_entry closes the set; the
// input then stalls while the row shifts left through cell 0 into the output
// register, one word per cycle while the output does not stall. Records that
// arrive with the row full are dropped and every word of that set carries
// overflow.
`include "mapped_area_insertion_sorter_assert.svh"

module mapped_area_insertion_sorter import mais_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	output logic      rec_stall,
	input  in_word_t  rec,
	output logic      sorted_valid,
	input  logic      sorted_stall,
	output out_word_t sorted
);

	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic             state_q;
	logic             state_d;
	logic [CNT_W-1:0] fill_q;
	logic             dropped_q;
	logic             out_valid_q;
	out_word_t        out_word_q;

	logic      acc_in;
	logic      full;
	logic      drain_step;
	cell_ctl_t ctl;
	rec_t      new_rec;
	rec_t      cell_rec [MAX_ENTRIES];
	logic      cell_gt  [MAX_ENTRIES];

	assign rec_stall  = (state_q == ST_DRAIN);
	assign acc_in     = rec_valid && !rec_stall;
	assign full       = (fill_q == CNT_W'(MAX_ENTRIES));
	assign drain_step = (state_q == ST_DRAIN) && (!out_valid_q || !sorted_stall);

	assign ctl.insert = acc_in && !full;
	assign ctl.drain  = drain_step;

	assign new_rec.key  = rec.start_address;
	assign new_rec.len  = rec.area_length;
	assign new_rec.off  = rec.area_offset;
	assign new_rec.perm = rec.permissions;
	assign new_rec.id   = rec.area_id;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		rec_t left_rec;
		rec_t right_rec;
		logic left_gt;

		if (i == 0) begin : g_head
			assign left_rec = new_rec;
			assign left_gt  = 1'b0;
		end else begin : g_body
			assign left_rec = cell_rec[i-1];
			assign left_gt  = cell_gt[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign right_rec = '0;
		end else begin : g_inner
			assign right_rec = cell_rec[i+1];
		end

		mais_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (fill_q > CNT_W'(i)),
			.first_free (fill_q == CNT_W'(i)),
			.left_gt    (left_gt),
			.new_rec    (new_rec),
			.left_rec   (left_rec),
			.right_rec  (right_rec),
			.rec        (cell_rec[i]),
			.gt         (cell_gt[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				if (acc_in && rec.last_entry) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_step && fill_q == CNT_W'(1)) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			fill_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.insert) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (drain_step) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (acc_in && full) begin
				dropped_q <= 1'b1;
			end else if (drain_step && fill_q == CNT_W'(1)) begin
				dropped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain_step) begin
			out_valid_q <= 1'b1;
		end else if (!sorted_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Take the head cell as the next word of the set.
	always_ff @(posedge clk) begin
		if (drain_step) begin
			out_word_q.sorted_start       <= cell_rec[0].key;
			out_word_q.sorted_length      <= cell_rec[0].len;
			out_word_q.sorted_offset      <= cell_rec[0].off;
			out_word_q.sorted_permissions <= cell_rec[0].perm;
			out_word_q.sorted_id          <= cell_rec[0].id;
			out_word_q.last_result        <= (fill_q == CNT_W'(1));
			out_word_q.overflow           <= dropped_q;
		end
	end

	assign sorted_valid = out_valid_q;
	assign sorted       = out_word_q;

	`MAIS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CNT_W'(MAX_ENTRIES), "fill count over capacity")
	`MAIS_ASSERT_NOW(a_drain_nonempty, state_q == ST_DRAIN, fill_q != '0, "draining an empty row")
	`MAIS_ASSERT_NOW(a_drop_full, dropped_q && state_q == ST_FILL, full, "drop flag with free cells")
	`MAIS_ASSERT_NEXT(a_set_done, drain_step && fill_q == CNT_W'(1), state_q == ST_FILL && fill_q == '0 && !dropped_q, "set not closed after final word")
	`MAIS_ASSERT_NEXT(a_insert_count, ctl.insert && !rec.last_entry, fill_q == $past(fill_q) + CNT_W'(1), "insert did not advance fill count")

endmodule
